FILE: rtl/tfhd_pkg.sv
package tfhd_pkg;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_LAUNCH   = 3'd1;
  localparam logic [2:0] EV_FREEFALL = 3'd2;
  localparam logic [2:0] EV_CAUGHT   = 3'd3;
  localparam logic [2:0] EV_LOST     = 3'd4;
  localparam logic [2:0] EV_TIMEOUT  = 3'd5;
  localparam logic [2:0] EV_SETTLED  = 3'd6;
  localparam logic [2:0] EV_HOLDOVER = 3'd7;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_LAUNCHED = 2'd1;
  localparam logic [1:0] PH_FREEFALL = 2'd2;
  localparam logic [1:0] PH_CAUGHT   = 2'd3;

  localparam logic [2:0] CFG_LAUNCH_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_FREEFALL_ENTER   = 3'd1;
  localparam logic [2:0] CFG_FLOAT_CEILING    = 3'd2;
  localparam logic [2:0] CFG_SETTLE_CEILING   = 3'd3;
  localparam logic [2:0] CFG_CATCH_THRESHOLD  = 3'd4;
  localparam logic [2:0] CFG_LAUNCH_TIMEOUT   = 3'd5;
  localparam logic [2:0] CFG_FREEFALL_TIMEOUT = 3'd6;
  localparam logic [2:0] CFG_RESULT_HOLD      = 3'd7;

  localparam int ADDR_W = 5;

  localparam logic [13:0] LAUNCH_THRESHOLD_RST = 14'd3000;
  localparam logic [13:0] FREEFALL_ENTER_RST   = 14'd300;
  localparam logic [13:0] FLOAT_CEILING_RST    = 14'd500;
  localparam logic [13:0] SETTLE_CEILING_RST   = 14'd2000;
  localparam logic [13:0] CATCH_THRESHOLD_RST  = 14'd1500;
  localparam logic [15:0] LAUNCH_TIMEOUT_RST   = 16'd500;
  localparam logic [13:0] FREEFALL_TIMEOUT_RST = 14'd3000;
  localparam logic [15:0] RESULT_HOLD_RST      = 16'd3000;

  localparam logic [3:0] MIN_FREEFALL_SAMPLES = 4'd3;
  localparam logic [2:0] COUNT_MAX            = 3'd7;

  // height = floor(T*T*981 / 800000): drop 2^8, then divide by 3125 via reciprocal
  localparam logic [9:0]  G_SCALE     = 10'd981;
  localparam logic [30:0] RECIP_3125  = 31'd1407374884;
  localparam int          RECIP_SHIFT = 42;
  localparam logic [16:0] HEIGHT_MAX  = 17'd131071;

  typedef struct packed {
    logic        cmd;
    logic [13:0] acc_mag_mg;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  phase;
    logic [16:0] height_mm;
    logic [13:0] freefall_ms;
  } result_t;

  typedef struct packed {
    logic [13:0] launch_threshold_mg;
    logic [13:0] freefall_enter_mg;
    logic [13:0] float_ceiling_mg;
    logic [13:0] settle_ceiling_mg;
    logic [13:0] catch_threshold_mg;
    logic [15:0] launch_timeout_ms;
    logic [13:0] freefall_timeout_ms;
    logic [15:0] result_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  phase;
    logic [13:0] tff;
  } stage_t;

endpackage

FILE: rtl/tfhd_cfg.sv
module tfhd_cfg
  import tfhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.launch_threshold_mg <= LAUNCH_THRESHOLD_RST;
      cfg.freefall_enter_mg   <= FREEFALL_ENTER_RST;
      cfg.float_ceiling_mg    <= FLOAT_CEILING_RST;
      cfg.settle_ceiling_mg   <= SETTLE_CEILING_RST;
      cfg.catch_threshold_mg  <= CATCH_THRESHOLD_RST;
      cfg.launch_timeout_ms   <= LAUNCH_TIMEOUT_RST;
      cfg.freefall_timeout_ms <= FREEFALL_TIMEOUT_RST;
      cfg.result_hold_ms      <= RESULT_HOLD_RST;
    end else if (wr) begin
      case (idx)
        CFG_LAUNCH_THRESHOLD: cfg.launch_threshold_mg <= pwdata[13:0];
        CFG_FREEFALL_ENTER:   cfg.freefall_enter_mg   <= pwdata[13:0];
        CFG_FLOAT_CEILING:    cfg.float_ceiling_mg    <= pwdata[13:0];
        CFG_SETTLE_CEILING:   cfg.settle_ceiling_mg   <= pwdata[13:0];
        CFG_CATCH_THRESHOLD:  cfg.catch_threshold_mg  <= pwdata[13:0];
        CFG_LAUNCH_TIMEOUT:   cfg.launch_timeout_ms   <= pwdata[15:0];
        CFG_FREEFALL_TIMEOUT: cfg.freefall_timeout_ms <= pwdata[13:0];
        CFG_RESULT_HOLD:      cfg.result_hold_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_LAUNCH_THRESHOLD: prdata = {18'd0, cfg.launch_threshold_mg};
      CFG_FREEFALL_ENTER:   prdata = {18'd0, cfg.freefall_enter_mg};
      CFG_FLOAT_CEILING:    prdata = {18'd0, cfg.float_ceiling_mg};
      CFG_SETTLE_CEILING:   prdata = {18'd0, cfg.settle_ceiling_mg};
      CFG_CATCH_THRESHOLD:  prdata = {18'd0, cfg.catch_threshold_mg};
      CFG_LAUNCH_TIMEOUT:   prdata = {16'd0, cfg.launch_timeout_ms};
      CFG_FREEFALL_TIMEOUT: prdata = {18'd0, cfg.freefall_timeout_ms};
      CFG_RESULT_HOLD:      prdata = {16'd0, cfg.result_hold_ms};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/tfhd_core.sv
module tfhd_core
  import tfhd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  input  logic    adv,
  output logic    s1_valid,
  output stage_t  s1
);

  logic        in_valid;
  sample_t     in_q;

  logic [1:0]  phase, phase_next;
  logic [31:0] launch_stamp, launch_stamp_next;
  logic [31:0] fall_start_stamp, fall_start_stamp_next;
  logic [31:0] hold_start_stamp, hold_start_stamp_next;
  logic [2:0]  fall_count, fall_count_next;

  logic [31:0] since_launch, since_fall, since_hold;
  logic [2:0]  count_inc;
  logic [2:0]  ev;
  logic [13:0] tff;
  logic        accept, step;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = in_valid && !adv;
  assign step         = in_valid && adv;

  assign since_launch = in_q.now_ms - launch_stamp;
  assign since_fall   = in_q.now_ms - fall_start_stamp;
  assign since_hold   = in_q.now_ms - hold_start_stamp;
  assign count_inc    = (fall_count != COUNT_MAX) ? fall_count + 3'd1 : fall_count;

  always_comb begin
    phase_next            = phase;
    launch_stamp_next     = launch_stamp;
    fall_start_stamp_next = fall_start_stamp;
    hold_start_stamp_next = hold_start_stamp;
    fall_count_next       = fall_count;
    ev                    = EV_NONE;
    tff                   = 14'd0;
    if (in_q.cmd) begin
      phase_next = PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (in_q.acc_mag_mg > cfg.launch_threshold_mg) begin
            launch_stamp_next = in_q.now_ms;
            phase_next        = PH_LAUNCHED;
            ev                = EV_LAUNCH;
          end
        end
        PH_LAUNCHED: begin
          if (in_q.acc_mag_mg < cfg.freefall_enter_mg) begin
            phase_next            = PH_FREEFALL;
            fall_start_stamp_next = in_q.now_ms;
            fall_count_next       = 3'd0;
            ev                    = EV_FREEFALL;
          end else if (since_launch > {16'd0, cfg.launch_timeout_ms}) begin
            phase_next = PH_IDLE;
            ev         = EV_TIMEOUT;
          end else if (in_q.acc_mag_mg < cfg.settle_ceiling_mg &&
                       in_q.acc_mag_mg > cfg.float_ceiling_mg) begin
            phase_next = PH_IDLE;
            ev         = EV_SETTLED;
          end
        end
        PH_FREEFALL: begin
          fall_count_next = count_inc;
          if (in_q.acc_mag_mg >= cfg.float_ceiling_mg &&
              in_q.acc_mag_mg > cfg.catch_threshold_mg &&
              {1'b0, count_inc} > MIN_FREEFALL_SAMPLES) begin
            phase_next            = PH_CAUGHT;
            hold_start_stamp_next = in_q.now_ms;
            ev                    = EV_CAUGHT;
            tff                   = since_fall[13:0];
          end
          // lost wins over a catch in the same sample
          if (since_fall > {18'd0, cfg.freefall_timeout_ms}) begin
            phase_next            = PH_IDLE;
            hold_start_stamp_next = in_q.now_ms;
            ev                    = EV_LOST;
            tff                   = 14'd0;
          end
        end
        default: begin
          if (since_hold > {16'd0, cfg.result_hold_ms}) begin
            phase_next = PH_IDLE;
            ev         = EV_HOLDOVER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      s1_valid         <= 1'b0;
      phase            <= PH_IDLE;
      launch_stamp     <= 32'd0;
      fall_start_stamp <= 32'd0;
      hold_start_stamp <= 32'd0;
      fall_count       <= 3'd0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv) begin
        s1_valid <= in_valid;
      end
      if (step) begin
        phase            <= phase_next;
        launch_stamp     <= launch_stamp_next;
        fall_start_stamp <= fall_start_stamp_next;
        hold_start_stamp <= hold_start_stamp_next;
        fall_count       <= fall_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= sample;
    end
    if (step) begin
      s1.event_res <= ev;
      s1.phase     <= phase_next;
      s1.tff       <= tff;
    end
  end

  a_caught_phase: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.event_res == EV_CAUGHT |-> s1.phase == PH_CAUGHT)
    else $error("caught event without caught phase");

  a_idle_events: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1.event_res == EV_LOST || s1.event_res == EV_TIMEOUT ||
                 s1.event_res == EV_SETTLED || s1.event_res == EV_HOLDOVER)
    |-> s1.phase == PH_IDLE)
    else $error("terminating event left phase active");

  a_tff_only_caught: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.event_res != EV_CAUGHT |-> s1.tff == 14'd0)
    else $error("freefall time outside caught event");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase) && $stable(fall_count))
    else $error("state advanced during stall");

endmodule

FILE: rtl/tfhd_height.sv
module tfhd_height
  import tfhd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s1_valid,
  input  stage_t  s1,
  output logic    adv,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        s2_valid, s3_valid;
  stage_t      s2, s3;
  logic [27:0] sq;
  logic [29:0] scaled;
  logic [37:0] scaled_full;
  logic [60:0] quot_full;
  logic [18:0] quot;
  logic [16:0] height;

  assign adv         = !result_valid || !result_stall;
  assign scaled_full = {10'd0, sq} * {28'd0, G_SCALE};
  assign quot_full   = {31'd0, scaled} * {30'd0, RECIP_3125};
  assign quot        = quot_full[RECIP_SHIFT +: 19];
  assign height      = (quot > {2'd0, HEIGHT_MAX}) ? HEIGHT_MAX : quot[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2     <= s1;
      sq     <= {14'd0, s1.tff} * {14'd0, s1.tff};
      s3     <= s2;
      scaled <= scaled_full[37:8];
      result.event_res   <= s3.event_res;
      result.phase       <= s3.phase;
      result.freefall_ms <= s3.tff;
      result.height_mm   <= height;
    end
  end

endmodule

FILE: rtl/toss_freefall_height_detector.sv
// Throughput: one sample per cycle while the output is not stalled; the phase update
// is a single registered step, and the height math runs in a fixed square / scale /
// reciprocal pipeline behind it, ending in the output register.
// The whole pipeline holds while a result is stalled.
// Reset (rst, synchronous): phase idle, stamps and count zero, registers to defaults.
module toss_freefall_height_detector
  import tfhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   adv;
  logic   s1_valid;
  stage_t s1;

  tfhd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfhd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .adv          (adv),
    .s1_valid     (s1_valid),
    .s1           (s1)
  );

  tfhd_height u_height (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .adv          (adv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: verif/testbench.sv
module testbench;
  import tfhd_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   MAG_TOP = 16000;

  logic              clk;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  sample_t           sample_data = '0;
  logic              result_valid;
  logic              result_stall;
  result_t           result_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic rx_stall = 1'b0;
  logic long_hold = 1'b0;
  assign result_stall = rx_stall | long_hold;

  toss_freefall_height_detector u_top (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predicted detector state
  logic [1:0]  toss_ph = PH_IDLE;
  logic [31:0] launch_at = '0;
  logic [31:0] fall_at = '0;
  logic [31:0] hold_at = '0;
  logic [2:0]  fall_cnt = '0;
  logic [15:0] cfg_val [0:7];

  result_t     toss_expect [$];
  int          err_count = 0;
  int          fed_count = 0;
  int          cycle_count = 0;
  int          hold_pending = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  logic [31:0] stamp_ms = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cfg_val[CFG_LAUNCH_THRESHOLD] = 16'(LAUNCH_THRESHOLD_RST);
    cfg_val[CFG_FREEFALL_ENTER]   = 16'(FREEFALL_ENTER_RST);
    cfg_val[CFG_FLOAT_CEILING]    = 16'(FLOAT_CEILING_RST);
    cfg_val[CFG_SETTLE_CEILING]   = 16'(SETTLE_CEILING_RST);
    cfg_val[CFG_CATCH_THRESHOLD]  = 16'(CATCH_THRESHOLD_RST);
    cfg_val[CFG_LAUNCH_TIMEOUT]   = LAUNCH_TIMEOUT_RST;
    cfg_val[CFG_FREEFALL_TIMEOUT] = 16'(FREEFALL_TIMEOUT_RST);
    cfg_val[CFG_RESULT_HOLD]      = RESULT_HOLD_RST;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void log_error(string msg);
    if (err_count < 10) $display("%s", msg);
    err_count++;
  endfunction

  function automatic result_t advance_toss(sample_t s);
    result_t     r;
    logic [31:0] elapsed;
    logic [63:0] h;
    r = '0;
    r.event_res = EV_NONE;
    if (s.cmd == CMD_CLEAR) begin
      toss_ph = PH_IDLE;
    end else begin
      case (toss_ph)
        PH_IDLE: begin
          if (s.acc_mag_mg > cfg_val[CFG_LAUNCH_THRESHOLD]) begin
            launch_at = s.now_ms;
            toss_ph = PH_LAUNCHED;
            r.event_res = EV_LAUNCH;
          end
        end
        PH_LAUNCHED: begin
          elapsed = s.now_ms - launch_at;
          if (s.acc_mag_mg < cfg_val[CFG_FREEFALL_ENTER]) begin
            toss_ph = PH_FREEFALL;
            fall_at = s.now_ms;
            fall_cnt = '0;
            r.event_res = EV_FREEFALL;
          end else if (elapsed > 32'(cfg_val[CFG_LAUNCH_TIMEOUT])) begin
            toss_ph = PH_IDLE;
            r.event_res = EV_TIMEOUT;
          end else if (s.acc_mag_mg < cfg_val[CFG_SETTLE_CEILING] &&
                       s.acc_mag_mg > cfg_val[CFG_FLOAT_CEILING]) begin
            toss_ph = PH_IDLE;
            r.event_res = EV_SETTLED;
          end
        end
        PH_FREEFALL: begin
          elapsed = s.now_ms - fall_at;
          if (fall_cnt != COUNT_MAX) fall_cnt = fall_cnt + 3'd1;
          if (s.acc_mag_mg >= cfg_val[CFG_FLOAT_CEILING] &&
              s.acc_mag_mg > cfg_val[CFG_CATCH_THRESHOLD] &&
              4'(fall_cnt) > MIN_FREEFALL_SAMPLES) begin
            toss_ph = PH_CAUGHT;
            hold_at = s.now_ms;
            r.event_res = EV_CAUGHT;
            r.freefall_ms = elapsed[13:0];
            h = (64'(r.freefall_ms) * 64'(r.freefall_ms) * 64'd981) / 64'd800000;
            r.height_mm = (h > 64'(HEIGHT_MAX)) ? HEIGHT_MAX : h[16:0];
          end
          // a timed-out fall wins over a catch in the same sample
          if (elapsed > 32'(cfg_val[CFG_FREEFALL_TIMEOUT])) begin
            toss_ph = PH_IDLE;
            hold_at = s.now_ms;
            r.event_res = EV_LOST;
            r.freefall_ms = '0;
            r.height_mm = '0;
          end
        end
        default: begin
          elapsed = s.now_ms - hold_at;
          if (elapsed > 32'(cfg_val[CFG_RESULT_HOLD])) begin
            toss_ph = PH_IDLE;
            r.event_res = EV_HOLDOVER;
          end
        end
      endcase
    end
    r.phase = toss_ph;
    return r;
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (toss_expect.size() == 0) begin
      log_error($sformatf("result with none expected: event %0d phase %0d height %0d ff %0d",
                          got.event_res, got.phase, got.height_mm, got.freefall_ms));
      return;
    end
    want = toss_expect.pop_front();
    if (got.event_res !== want.event_res)
      log_error($sformatf("event_res: expected %0d got %0d", want.event_res, got.event_res));
    if (got.phase !== want.phase)
      log_error($sformatf("phase: expected %0d got %0d", want.phase, got.phase));
    if (got.height_mm !== want.height_mm)
      log_error($sformatf("height_mm: expected %0d got %0d", want.height_mm, got.height_mm));
    if (got.freefall_ms !== want.freefall_ms)
      log_error($sformatf("freefall_ms: expected %0d got %0d",
                          want.freefall_ms, got.freefall_ms));
  endfunction

  initial begin : receiver
    int      pause;
    result_t got;
    forever begin
      pause = rx_idle_on ? $urandom_range(13, 0) : 0;
      if (pause > 0) begin
        rx_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      rx_stall <= 1'b0;
      forever begin
        @(negedge clk);
        if (result_valid && !result_stall) break;
        @(posedge clk);
      end
      got = result_data;
      @(posedge clk);
      check_result(got);
    end
  end

  initial begin : long_stall
    int n;
    forever begin
      @(negedge clk);
      if (hold_pending > 0) begin
        n = hold_pending;
        hold_pending = 0;
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (n) @(posedge clk);
        long_hold <= 1'b0;
      end
    end
  end

  task automatic feed(input logic cmd, input int unsigned mag, input int unsigned dt);
    sample_t s;
    int      gap;
    stamp_ms = stamp_ms + dt;
    s.cmd = cmd;
    s.acc_mag_mg = 14'(mag);
    s.now_ms = stamp_ms;
    gap = tx_idle_on ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data <= s;
    forever begin
      @(negedge clk);
      if (!sample_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    toss_expect.push_back(advance_toss(s));
    fed_count++;
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (toss_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LAUNCH_TIMEOUT || idx == CFG_RESULT_HOLD) cfg_val[idx] = val;
    else cfg_val[idx] = val & 16'h3FFF;
  endtask

  task automatic read_reg(input logic [2:0] idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== 32'(cfg_val[idx]))
      log_error($sformatf("register %0d readback: expected %0d got %0d",
                          idx, cfg_val[idx], got));
  endtask

  task automatic load_config(input cfg_t c);
    wait_drained();
    write_reg(CFG_LAUNCH_THRESHOLD, 16'(c.launch_threshold_mg));
    write_reg(CFG_FREEFALL_ENTER, 16'(c.freefall_enter_mg));
    write_reg(CFG_FLOAT_CEILING, 16'(c.float_ceiling_mg));
    write_reg(CFG_SETTLE_CEILING, 16'(c.settle_ceiling_mg));
    write_reg(CFG_CATCH_THRESHOLD, 16'(c.catch_threshold_mg));
    write_reg(CFG_LAUNCH_TIMEOUT, c.launch_timeout_ms);
    write_reg(CFG_FREEFALL_TIMEOUT, 16'(c.freefall_timeout_ms));
    write_reg(CFG_RESULT_HOLD, c.result_hold_ms);
    for (int i = 0; i < 8; i++) read_reg(3'(i));
  endtask

  function automatic cfg_t make_cfg(int unsigned launch, int unsigned enter,
                                    int unsigned flt, int unsigned settle,
                                    int unsigned catch_mg, int unsigned launch_to,
                                    int unsigned fall_to, int unsigned hold);
    cfg_t c;
    c.launch_threshold_mg = 14'(launch);
    c.freefall_enter_mg   = 14'(enter);
    c.float_ceiling_mg    = 14'(flt);
    c.settle_ceiling_mg   = 14'(settle);
    c.catch_threshold_mg  = 14'(catch_mg);
    c.launch_timeout_ms   = 16'(launch_to);
    c.freefall_timeout_ms = 14'(fall_to);
    c.result_hold_ms      = 16'(hold);
    return c;
  endfunction

  function automatic cfg_t default_cfg();
    return make_cfg(LAUNCH_THRESHOLD_RST, FREEFALL_ENTER_RST, FLOAT_CEILING_RST,
                    SETTLE_CEILING_RST, CATCH_THRESHOLD_RST, LAUNCH_TIMEOUT_RST,
                    FREEFALL_TIMEOUT_RST, RESULT_HOLD_RST);
  endfunction

  function automatic cfg_t random_cfg();
    int unsigned enter, flt, settle, launch;
    if ($urandom_range(4, 0) == 0)
      return make_cfg($urandom_range(MAG_TOP, 0), $urandom_range(MAG_TOP, 0),
                      $urandom_range(MAG_TOP, 0), $urandom_range(MAG_TOP, 0),
                      $urandom_range(MAG_TOP, 0), $urandom_range(65535, 0),
                      $urandom_range(10000, 0), $urandom_range(65535, 0));
    enter  = $urandom_range(600, 50);
    flt    = enter + $urandom_range(400, 0);
    settle = flt + $urandom_range(2500, 200);
    launch = settle + $urandom_range(4000, 1);
    return make_cfg(launch, enter, flt, settle, $urandom_range(launch, flt),
                    $urandom_range(2000, 20), $urandom_range(10000, 100),
                    $urandom_range(4000, 0));
  endfunction

  function automatic int unsigned mag_over(int unsigned lim);
    if (lim >= MAG_TOP) return MAG_TOP;
    return $urandom_range(MAG_TOP, lim + 1);
  endfunction

  function automatic int unsigned mag_under(int unsigned lim);
    if (lim == 0) return 0;
    return $urandom_range(lim - 1, 0);
  endfunction

  task automatic feed_noise();
    int unsigned dt;
    case ($urandom_range(9, 0))
      0:       dt = $urandom();
      1, 2:    dt = $urandom_range(5000, 0);
      default: dt = $urandom_range(200, 0);
    endcase
    feed(($urandom_range(19, 0) == 0) ? CMD_CLEAR : CMD_SAMPLE,
         $urandom_range(MAG_TOP, 0), dt);
  endtask

  // idle -> launch -> launched -> freefall -> catch -> hold, random content
  task automatic toss_sequence();
    int          n;
    int unsigned lo;
    n = $urandom_range(2, 0);
    repeat (n) feed(CMD_SAMPLE, $urandom_range(cfg_val[CFG_LAUNCH_THRESHOLD], 0),
                    $urandom_range(50, 1));
    feed(CMD_SAMPLE, mag_over(cfg_val[CFG_LAUNCH_THRESHOLD]), $urandom_range(50, 1));
    lo = (cfg_val[CFG_FREEFALL_ENTER] > cfg_val[CFG_SETTLE_CEILING]) ?
         cfg_val[CFG_FREEFALL_ENTER] : cfg_val[CFG_SETTLE_CEILING];
    n = $urandom_range(3, 0);
    repeat (n) feed(CMD_SAMPLE, (lo == 0) ? 0 : mag_over(lo - 1),
                    $urandom_range(cfg_val[CFG_LAUNCH_TIMEOUT] / 4 + 1, 1));
    if ($urandom_range(9, 0) == 0)
      feed(CMD_CLEAR, $urandom_range(MAG_TOP, 0), $urandom_range(50, 0));
    feed(CMD_SAMPLE, mag_under(cfg_val[CFG_FREEFALL_ENTER]),
         $urandom_range(cfg_val[CFG_LAUNCH_TIMEOUT] / 2 + 1, 1));
    n = $urandom_range(8, 1);
    repeat (n) feed(CMD_SAMPLE, mag_under(cfg_val[CFG_FLOAT_CEILING]),
                    $urandom_range(cfg_val[CFG_FREEFALL_TIMEOUT] / 4 + 1, 1));
    lo = (cfg_val[CFG_CATCH_THRESHOLD] + 1 > cfg_val[CFG_FLOAT_CEILING]) ?
         cfg_val[CFG_CATCH_THRESHOLD] + 1 : cfg_val[CFG_FLOAT_CEILING];
    feed(CMD_SAMPLE,
         ($urandom_range(6, 0) != 0) ? mag_over(lo - 1) : $urandom_range(MAG_TOP, 0),
         $urandom_range(cfg_val[CFG_FREEFALL_TIMEOUT] / 4 + 1, 1));
    n = $urandom_range(3, 0);
    repeat (n) feed(CMD_SAMPLE, $urandom_range(MAG_TOP, 0),
                    $urandom_range(cfg_val[CFG_RESULT_HOLD] / 2 + 1, 0));
  endtask

  task automatic test_directed_toss();
    stamp_ms = 32'hFFFF_FF00;
    feed(CMD_SAMPLE, 0, 0);
    feed(CMD_SAMPLE, 3000, 5);
    feed(CMD_SAMPLE, MAG_TOP, 5);
    feed(CMD_SAMPLE, 2000, 10);
    feed(CMD_SAMPLE, 299, 10);
    repeat (3) feed(CMD_SAMPLE, 0, 100);
    feed(CMD_SAMPLE, MAG_TOP, 100);
    feed(CMD_SAMPLE, 8000, 3000);
    feed(CMD_SAMPLE, 8000, 1);
    feed(CMD_SAMPLE, 3001, 10);
    feed(CMD_SAMPLE, 1000, 10);
    feed(CMD_SAMPLE, 3001, 10);
    feed(CMD_SAMPLE, 2500, 501);
    feed(CMD_SAMPLE, MAG_TOP, 10);
    feed(CMD_SAMPLE, 0, 10);
    feed(CMD_SAMPLE, MAG_TOP, 10);
    repeat (3) feed(CMD_SAMPLE, 600, 10);
    feed(CMD_SAMPLE, MAG_TOP, 2961);
    feed(CMD_SAMPLE, MAG_TOP, 10);
    feed(CMD_CLEAR, MAG_TOP, 10);
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    load_config(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
    feed(CMD_SAMPLE, 0, 1);
    feed(CMD_SAMPLE, 1, 1);
    feed(CMD_SAMPLE, 0, 0);
    feed(CMD_SAMPLE, 0, 1);
    feed(CMD_SAMPLE, 5, 1);
    feed(CMD_CLEAR, 0, 1);
    load_config(make_cfg(MAG_TOP, MAG_TOP, MAG_TOP, MAG_TOP, MAG_TOP, 65535, 10000, 65535));
    feed(CMD_SAMPLE, MAG_TOP, 1);
    c = default_cfg();
    c.freefall_timeout_ms = 14'd10000;
    load_config(c);
    feed(CMD_SAMPLE, MAG_TOP, 1);
    feed(CMD_SAMPLE, 0, 1);
    repeat (3) feed(CMD_SAMPLE, 0, 1000);
    feed(CMD_SAMPLE, MAG_TOP, 7000);
    feed(CMD_CLEAR, MAG_TOP, 1);
    // widest fall time: height saturates
    c.freefall_timeout_ms = 14'h3FFF;
    load_config(c);
    feed(CMD_SAMPLE, MAG_TOP, 1);
    feed(CMD_SAMPLE, 0, 1);
    repeat (3) feed(CMD_SAMPLE, 0, 1000);
    feed(CMD_SAMPLE, MAG_TOP, 13383);
    feed(CMD_CLEAR, MAG_TOP, 1);
  endtask

  task automatic test_random_tosses();
    int start;
    for (int ph = 0; ph < 5; ph++) begin
      load_config((ph == 0) ? default_cfg() : random_cfg());
      stamp_ms = $urandom();
      start = fed_count;
      while (fed_count - start < 205) begin
        tx_idle_on = ($urandom_range(4, 0) != 0);
        rx_idle_on = ($urandom_range(4, 0) != 0);
        if ($urandom_range(3, 0) != 0) toss_sequence();
        else repeat ($urandom_range(4, 1)) feed_noise();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    load_config(default_cfg());
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_pending = 300;
    repeat (3) toss_sequence();
    repeat (30) feed_noise();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_toss();
    test_register_extremes();
    test_random_tosses();
    test_output_backpressure();
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0 && toss_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
